/* hdl/glyph_text_layout_core_defines.svh */
// Assertion macros used by the glyph text layout RTL.
// Each macro checks against the module's clk and rst; nothing else is needed.
`ifndef GLYPH_TEXT_LAYOUT_CORE_DEFINES_SVH
`define GLYPH_TEXT_LAYOUT_CORE_DEFINES_SVH

`ifndef SYNTH

`define GTL_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define GTL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define GTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define GTL_ASSERT(lbl, expr, msg)

`define GTL_ASSERT_IMPL(lbl, ante, cons, msg)

`define GTL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/gtl_pkg.sv */
// Shared types, codes and defaults of the glyph text layout block.
// No dependencies; every module of the block imports this package.
package gtl_pkg;

  localparam int GTL_GLYPH_ENTRIES = 128;
  localparam int GTL_BATCH_SIZE    = 64;

  // Pen step for a tab is four space widths, done as a shift by two.
  localparam int TAB_SHIFT = 2;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [14:0] SPACE_ADVANCE_RST = 15'd128;
  localparam logic [14:0] NEWLINE_STEP_RST  = 15'd256;
  localparam logic [7:0]  FIRST_CODE_RST    = 8'd32;
  localparam logic [7:0]  LAST_CODE_RST     = 8'd126;
  localparam logic [14:0] GLYPH_SIZE_RST    = 15'd256;

  typedef enum logic [2:0] {
    REG_SPACE_ADVANCE = 3'd0,
    REG_NEWLINE_STEP  = 3'd1,
    REG_FIRST_CODE    = 3'd2,
    REG_LAST_CODE     = 3'd3,
    REG_GLYPH_SIZE    = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_CHAR   = 2'd1,
    CMD_METRIC = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_GLYPH = 2'd0,
    ST_FLUSH = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] off_x;
    logic [15:0] off_y;
    logic [14:0] adv;
  } metric_t;

  // Decoded character word, registered in the read stage.
  typedef struct packed {
    cmd_t        cmd;
    logic        is_space;
    logic        is_tab;
    logic        is_newline;
    logic        in_range;
    logic [7:0]  glyph_index;
    logic        last;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } item_t;

  typedef struct packed {
    logic [14:0] space_advance;
    logic [14:0] newline_step;
    logic [14:0] glyph_size;
  } layout_cfg_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] glyph_x;
    logic [15:0] glyph_y;
    logic [7:0]  glyph_index;
    logic [5:0]  slot;
    logic        flush;
    logic [6:0]  batch_count;
  } result_t;

endpackage

/* hdl/gtl_metric_mem.sv */
// Glyph metric store: one write port and one registered read port.
// Depends on gtl_pkg for the metric entry type.
module gtl_metric_mem
  import gtl_pkg::*;
#(
  parameter int ENTRIES = GTL_GLYPH_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  metric_t       wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output metric_t       rdata
);

  metric_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no new read is issued, so a stalled word keeps it.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/gtl_layout_stage.sv */
// Pen and batch state update plus the output register of the layout pipe.
// Depends on gtl_pkg and the assertion macros in glyph_text_layout_core_defines.svh.
`include "glyph_text_layout_core_defines.svh"

module gtl_layout_stage
  import gtl_pkg::*;
#(
  parameter int BATCH_SIZE = GTL_BATCH_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  layout_cfg_t cfg,
  input  logic        item_valid,
  input  item_t       item,
  input  metric_t     metric,
  output logic        item_fire,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  localparam int FW = $clog2(BATCH_SIZE + 1);
  localparam logic [FW-1:0] BATCH_MAX = FW'(BATCH_SIZE);

  logic [15:0]   pen_x, pen_x_next;
  logic [15:0]   pen_y, pen_y_next;
  logic [15:0]   line_start_x, line_start_x_next;
  logic [FW-1:0] batch_fill, batch_fill_next;
  logic [FW-1:0] fill_inc;
  logic [8:0]    fill_ext, inc_ext;
  logic          res_valid;
  result_t       res;

  assign item_fire = item_valid && (!out_valid || out_ready);
  assign fill_inc  = batch_fill + FW'(1);
  assign fill_ext  = 9'(batch_fill);
  assign inc_ext   = 9'(fill_inc);

  always_comb begin
    pen_x_next        = pen_x;
    pen_y_next        = pen_y;
    line_start_x_next = line_start_x;
    batch_fill_next   = batch_fill;
    res_valid         = 1'b0;
    res               = '0;
    if (item_fire) begin
      unique case (item.cmd)
        CMD_START: begin
          pen_x_next        = item.origin_x;
          pen_y_next        = item.origin_y;
          line_start_x_next = item.origin_x;
          batch_fill_next   = '0;
        end
        CMD_CHAR: begin
          if (item.is_space || item.is_tab || item.is_newline) begin
            if (item.is_space) begin
              pen_x_next = pen_x + 16'(cfg.space_advance);
            end else if (item.is_tab) begin
              pen_x_next = pen_x + 16'(17'(cfg.space_advance) << TAB_SHIFT);
            end else begin
              pen_x_next = line_start_x;
              pen_y_next = pen_y - 16'(cfg.newline_step);
            end
            if (item.last && batch_fill != '0) begin
              res_valid       = 1'b1;
              res.status      = ST_FLUSH;
              res.flush       = 1'b1;
              res.batch_count = fill_ext[6:0];
              batch_fill_next = '0;
            end
          end else if (!item.in_range) begin
            res_valid       = 1'b1;
            res.status      = ST_RANGE;
            res.glyph_index = item.glyph_index;
            if (item.last && batch_fill != '0) begin
              res.flush       = 1'b1;
              res.batch_count = fill_ext[6:0];
              batch_fill_next = '0;
            end
          end else begin
            res_valid       = 1'b1;
            res.status      = ST_GLYPH;
            res.glyph_x     = pen_x + metric.off_x;
            res.glyph_y     = pen_y - (16'(cfg.glyph_size) + metric.off_y);
            res.glyph_index = item.glyph_index;
            res.slot        = fill_ext[5:0];
            pen_x_next      = pen_x + 16'(metric.adv);
            if (fill_inc >= BATCH_MAX || item.last) begin
              res.flush       = 1'b1;
              res.batch_count = inc_ext[6:0];
              batch_fill_next = '0;
            end else begin
              batch_fill_next = fill_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      line_start_x <= '0;
      batch_fill   <= '0;
      out_valid    <= 1'b0;
    end else begin
      pen_x        <= pen_x_next;
      pen_y        <= pen_y_next;
      line_start_x <= line_start_x_next;
      batch_fill   <= batch_fill_next;
      if (item_fire) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && res_valid) begin
      out_res <= res;
    end
  end

  `GTL_ASSERT(a_fill_below_batch, batch_fill < BATCH_MAX, "batch fill reached batch size")
  `GTL_ASSERT_IMPL(a_count_needs_flush, out_valid && !out_res.flush, out_res.batch_count == '0,
    "batch count set without flush")
  `GTL_ASSERT_IMPL(a_flush_status, out_valid && out_res.status == ST_FLUSH, out_res.flush,
    "flush-only word without flush")
  `GTL_ASSERT_NEXT(a_item_held, item_valid && !item_fire, item_valid,
    "stalled word lost in read stage")

endmodule

/* hdl/glyph_text_layout_core.sv */
// Glyph text layout block: stream in, command decode, metric store and layout stage.
// Depends on gtl_pkg, gtl_metric_mem and gtl_layout_stage.
//
// Usage: words enter on the s_ group. tuser carries the command: start sets the
// pen and line start to the given origin, char lays out one character, metric
// loads one glyph store entry. tlast marks the final character of a string.
// Results leave on the m_ group, at most one per word: tuser is the status,
// tlast is flush, tdata the glyph position, index, batch slot and batch count.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle, which the block does not enforce.
// Order: the word and its metric store read are registered on acceptance, then
// the pen update lands in the output register when the layout stage takes the
// word, which a receiver stall can delay. Throughput is one word per cycle
// while m_tready is high; the pen update after the registered metric read keeps up.
// Reset clears the pen, line start and batch fill and loads the register
// defaults; glyph store entries hold nothing valid until written.
// When the receiver stalls, one result waits in the output register and one
// word in the read stage; then s_tready drops until the result is taken.
module glyph_text_layout_core
  import gtl_pkg::*;
#(
  parameter int GLYPH_ENTRIES = GTL_GLYPH_ENTRIES,
  parameter int BATCH_SIZE    = GTL_BATCH_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // char_code[7:0], origin_x[23:8], origin_y[39:24], metric_slot[46:40],
  // metric_offset_x[62:47], metric_offset_y[78:63], metric_advance[93:79], zero fill
  input  logic [95:0] s_tdata,
  input  logic        s_tlast,  // last_char
  input  logic [1:0]  s_tuser,  // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  // glyph_x[15:0], glyph_y[31:16], glyph_index[39:32], slot[45:40],
  // batch_count[52:46], zero fill
  output logic [55:0] m_tdata,
  output logic        m_tlast,  // flush
  output logic [1:0]  m_tuser,  // status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int AW = $clog2(GLYPH_ENTRIES);
  localparam logic [8:0] ENTRY_LIMIT = 9'(GLYPH_ENTRIES);

  logic [14:0] space_advance, newline_step, glyph_size;
  logic [7:0]  first_code, last_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      space_advance <= SPACE_ADVANCE_RST;
      newline_step  <= NEWLINE_STEP_RST;
      first_code    <= FIRST_CODE_RST;
      last_code     <= LAST_CODE_RST;
      glyph_size    <= GLYPH_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPACE_ADVANCE: space_advance <= cfg_data;
        REG_NEWLINE_STEP:  newline_step  <= cfg_data;
        REG_FIRST_CODE:    first_code    <= cfg_data[7:0];
        REG_LAST_CODE:     last_code     <= cfg_data[7:0];
        REG_GLYPH_SIZE:    glyph_size    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic        accept;
  cmd_t        in_cmd;
  logic [7:0]  char_code;
  logic [6:0]  metric_slot;
  logic [7:0]  glyph_index;
  logic [8:0]  index_ext, slot_ext;
  item_t       item_d, item_q;
  logic        item_valid;
  logic        item_fire;
  metric_t     wr_metric, rd_metric;
  layout_cfg_t layout_cfg;
  logic        out_valid;
  result_t     out_res;

  assign accept      = s_tvalid && s_tready;
  assign s_tready    = !item_valid || item_fire;
  assign in_cmd      = cmd_t'(s_tuser);
  assign char_code   = s_tdata[7:0];
  assign metric_slot = s_tdata[46:40];
  assign glyph_index = char_code - first_code;
  assign index_ext   = 9'(glyph_index);
  assign slot_ext    = 9'(metric_slot);

  assign wr_metric.off_x = s_tdata[62:47];
  assign wr_metric.off_y = s_tdata[78:63];
  assign wr_metric.adv   = s_tdata[93:79];

  always_comb begin
    item_d             = '0;
    item_d.cmd         = in_cmd;
    item_d.is_space    = char_code == CH_SPACE;
    item_d.is_tab      = char_code == CH_TAB;
    item_d.is_newline  = char_code == CH_NEWLINE;
    item_d.in_range    = char_code >= first_code && char_code <= last_code &&
                         index_ext < ENTRY_LIMIT;
    item_d.glyph_index = glyph_index;
    item_d.last        = s_tlast;
    item_d.origin_x    = s_tdata[23:8];
    item_d.origin_y    = s_tdata[39:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  // Writes land at accept and reads issue at accept, so a metric word is
  // seen by every later character word without forwarding.
  gtl_metric_mem #(
    .ENTRIES(GLYPH_ENTRIES)
  ) u_metric_mem (
    .clk  (clk),
    .we   (accept && in_cmd == CMD_METRIC && slot_ext < ENTRY_LIMIT),
    .waddr(slot_ext[AW-1:0]),
    .wdata(wr_metric),
    .re   (accept && in_cmd == CMD_CHAR),
    .raddr(index_ext[AW-1:0]),
    .rdata(rd_metric)
  );

  assign layout_cfg.space_advance = space_advance;
  assign layout_cfg.newline_step  = newline_step;
  assign layout_cfg.glyph_size    = glyph_size;

  gtl_layout_stage #(
    .BATCH_SIZE(BATCH_SIZE)
  ) u_layout_stage (
    .clk       (clk),
    .rst       (rst),
    .cfg       (layout_cfg),
    .item_valid(item_valid),
    .item      (item_q),
    .metric    (rd_metric),
    .item_fire (item_fire),
    .out_valid (out_valid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tlast  = out_res.flush;
  assign m_tdata  = {3'b000, out_res.batch_count, out_res.slot, out_res.glyph_index,
                     out_res.glyph_y, out_res.glyph_x};

endmodule
